/* rtl/mba_pkg.sv */
package mba_pkg;

   localparam int DefMaxWidth  = 640;
   localparam int DefMaxHeight = 480;
   localparam int DefMaxMosaic = 64;

   localparam logic [1:0] RegFrameWidth  = 2'd0;
   localparam logic [1:0] RegFrameHeight = 2'd1;
   localparam logic [1:0] RegMosaicSize  = 2'd2;

   localparam logic [9:0] ResetFrameWidth  = 10'd640;
   localparam logic [9:0] ResetFrameHeight = 10'd480;
   localparam logic [9:0] ResetMosaicSize  = 10'd2;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_RD_RD,
      ST_RD_LD,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic       frame_ready;
      logic [1:0] q_count;
   } front_status_type;

endpackage

/* rtl/mba_walk.sv */
module mba_walk
   import mba_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight,
   parameter int MAX_MOSAIC = DefMaxMosaic,
   localparam int XW    = $clog2(MAX_WIDTH + 1),
   localparam int YW    = $clog2(MAX_HEIGHT + 1),
   localparam int MW    = $clog2(MAX_MOSAIC + 1),
   localparam int CNTW  = 2 * MW,
   localparam int DEPTH = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2),
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            restart,
   input  logic            step,
   input  logic [XW-1:0]   w,
   input  logic [YW-1:0]   h,
   input  logic [MW-1:0]   m,
   output logic [AW-1:0]   addr,
   output logic            first,
   output logic [CNTW-1:0] cnt,
   output logic            last
);

   logic [XW-1:0] col_ff, col_in, tx_ff, tx_in;
   logic [YW-1:0] row_ff, row_in;
   logic [MW-1:0] offx_ff, offx_in, offy_ff, offy_in;
   logic [AW-1:0] base_ff, base_in;
   logic [XW-1:0] remw;
   logic [YW-1:0] remh;
   logic [MW-1:0] cw, ch;
   logic          end_col, end_row;

   assign end_col = (col_ff == XW'(w - 1'b1));
   assign end_row = (row_ff == YW'(h - 1'b1));
   assign last    = end_col && end_row;
   assign first   = (offx_ff == '0) && (offy_ff == '0);
   assign addr    = AW'(base_ff + AW'(tx_ff));

   // Clipped tile extent: distance from the tile origin to the frame edge, capped at m.
   always_comb begin
      remw = XW'(w - (col_ff - XW'(offx_ff)));
      remh = YW'(h - (row_ff - YW'(offy_ff)));
      cw   = (int'(remw) < int'(m)) ? MW'(remw) : m;
      ch   = (int'(remh) < int'(m)) ? MW'(remh) : m;
      cnt  = CNTW'(cw) * CNTW'(ch);
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      offx_in = offx_ff;
      offy_in = offy_ff;
      tx_in   = tx_ff;
      base_in = base_ff;
      if (step) begin
         if (end_col) begin
            col_in  = '0;
            offx_in = '0;
            tx_in   = '0;
            if (end_row) begin
               row_in  = '0;
               offy_in = '0;
               base_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (offy_ff == MW'(m - 1'b1)) begin
                  offy_in = '0;
                  base_in = AW'(base_ff + AW'(tx_ff) + 1'b1);
               end else begin
                  offy_in = offy_ff + 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (offx_ff == MW'(m - 1'b1)) begin
               offx_in = '0;
               tx_in   = tx_ff + 1'b1;
            end else begin
               offx_in = offx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         offx_ff <= '0;
         offy_ff <= '0;
         tx_ff   <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         tx_ff   <= tx_in;
         base_ff <= base_in;
      end
   end

endmodule

/* rtl/mba_front.sv */
module mba_front
   import mba_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight,
   parameter int MAX_MOSAIC = DefMaxMosaic,
   localparam int XW    = $clog2(MAX_WIDTH + 1),
   localparam int YW    = $clog2(MAX_HEIGHT + 1),
   localparam int MW    = $clog2(MAX_MOSAIC + 1),
   localparam int CNTW  = 2 * MW,
   localparam int DEPTH = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2),
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [XW-1:0]    w,
   input  logic [YW-1:0]    h,
   input  logic [MW-1:0]    m,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cmd,
   input  logic [31:0]      req_pixel,
   output logic             q_valid,
   input  logic             q_pop,
   output op_type           q_op,
   output logic [AW-1:0]    q_addr,
   output logic             q_first,
   output logic [31:0]      q_pixel,
   output logic [CNTW-1:0]  q_cnt,
   output logic             q_last,
   output front_status_type status
);

   logic            ready_ff, ready_in;
   logic [1:0]      count_ff, count_in;
   logic            wp_ff, rp_ff;
   op_type          op_ff    [2];
   logic [AW-1:0]   addr_ff  [2];
   logic            first_ff [2];
   logic [31:0]     pix_ff   [2];
   logic [CNTW-1:0] cnt_ff   [2];
   logic            last_ff  [2];

   logic            accept, do_load, do_read, push;
   logic [AW-1:0]   ld_addr, rd_addr;
   logic            ld_first, rd_first, ld_last, rd_last;
   logic [CNTW-1:0] ld_cnt, rd_cnt;

   assign req_ready = (count_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   // Loads are dropped once the frame is complete, reads are dropped until it is.
   assign do_load   = accept && (req_cmd == OP_LOAD) && !ready_ff;
   assign do_read   = accept && (req_cmd == OP_READ) && ready_ff;
   assign push      = do_load || do_read;

   mba_walk #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_MOSAIC(MAX_MOSAIC)
   ) u_load_walk (
      .clock  (clock),
      .reset  (reset),
      .restart(restart),
      .step   (do_load),
      .w      (w),
      .h      (h),
      .m      (m),
      .addr   (ld_addr),
      .first  (ld_first),
      .cnt    (ld_cnt),
      .last   (ld_last)
   );

   mba_walk #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_MOSAIC(MAX_MOSAIC)
   ) u_read_walk (
      .clock  (clock),
      .reset  (reset),
      .restart(restart),
      .step   (do_read),
      .w      (w),
      .h      (h),
      .m      (m),
      .addr   (rd_addr),
      .first  (rd_first),
      .cnt    (rd_cnt),
      .last   (rd_last)
   );

   always_comb begin
      ready_in = ready_ff;
      if (do_load && ld_last) begin
         ready_in = 1'b1;
      end else if (do_read && rd_last) begin
         ready_in = 1'b0;
      end
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         count_ff <= '0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
      end else begin
         ready_ff <= restart ? 1'b0 : ready_in;
         count_ff <= count_in;
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (q_pop) begin
            rp_ff <= !rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wp_ff]    <= do_read ? OP_READ : OP_LOAD;
         addr_ff[wp_ff]  <= do_read ? rd_addr : ld_addr;
         first_ff[wp_ff] <= do_read ? rd_first : ld_first;
         pix_ff[wp_ff]   <= req_pixel;
         cnt_ff[wp_ff]   <= do_read ? rd_cnt : ld_cnt;
         last_ff[wp_ff]  <= do_read && rd_last;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_op    = op_ff[rp_ff];
   assign q_addr  = addr_ff[rp_ff];
   assign q_first = first_ff[rp_ff];
   assign q_pixel = pix_ff[rp_ff];
   assign q_cnt   = cnt_ff[rp_ff];
   assign q_last  = last_ff[rp_ff];

   assign status.frame_ready = ready_ff;
   assign status.q_count     = count_ff;

endmodule

/* rtl/mba_back.sv */
module mba_back
   import mba_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight,
   parameter int MAX_MOSAIC = DefMaxMosaic,
   localparam int MW    = $clog2(MAX_MOSAIC + 1),
   localparam int CNTW  = 2 * MW,
   localparam int DVW   = CNTW + 7,
   localparam int SUMW  = $clog2(MAX_MOSAIC * MAX_MOSAIC * 255 + 1),
   localparam int DEPTH = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2),
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_pop,
   input  op_type          q_op,
   input  logic [AW-1:0]   q_addr,
   input  logic            q_first,
   input  logic [31:0]     q_pixel,
   input  logic [CNTW-1:0] q_cnt,
   input  logic            q_last,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [31:0]     out_pixel,
   output logic            out_last
);

   logic [4*SUMW-1:0] mem [DEPTH];
   logic [4*SUMW-1:0] rdata_ff, wdata;
   logic              we;

   state_type       state_ff, state_in;
   logic [AW-1:0]   addr_ff;
   logic            first_ff, last_ff;
   logic [31:0]     pix_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [2:0]      step_ff;
   logic [DVW-1:0]  div_ff;
   logic [SUMW-1:0] rem_ff  [4];
   logic [SUMW-1:0] rem_in  [4];
   logic [7:0]      quot_ff [4];
   logic [7:0]      quot_in [4];
   logic            div_go, out_free;
   logic            ovalid_ff;
   logic [31:0]     opix_ff;
   logic            olast_ff;

   assign out_free  = !ovalid_ff || out_ready;
   assign out_valid = ovalid_ff;
   assign out_pixel = opix_ff;
   assign out_last  = olast_ff;

   // The final quotient bit waits until the output register can take the result.
   assign div_go = (state_ff == ST_DIV) && ((step_ff != 3'd0) || out_free);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic ge;
         ge         = (DVW'(rem_ff[c]) >= div_ff);
         rem_in[c]  = ge ? SUMW'(DVW'(rem_ff[c]) - div_ff) : rem_ff[c];
         quot_in[c] = {quot_ff[c][6:0], ge};
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         wdata[c*SUMW +: SUMW] = first_ff ? SUMW'(pix_ff[c*8 +: 8])
                               : SUMW'(rdata_ff[c*SUMW +: SUMW] + SUMW'(pix_ff[c*8 +: 8]));
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = (q_op == OP_READ) ? ST_RD_RD : ST_LD_RD;
            end
         end
         ST_LD_RD: state_in = ST_LD_WR;
         ST_LD_WR: begin
            we       = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RD_RD: state_in = ST_RD_LD;
         ST_RD_LD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_go && (step_ff == 3'd0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr_ff] <= wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_go && (step_ff == 3'd0)) begin
            ovalid_ff <= 1'b1;
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         addr_ff  <= q_addr;
         first_ff <= q_first;
         pix_ff   <= q_pixel;
         cnt_ff   <= q_cnt;
         last_ff  <= q_last;
      end
      if (state_ff == ST_RD_LD) begin
         div_ff  <= DVW'(cnt_ff) << 7;
         step_ff <= 3'd7;
         for (int c = 0; c < 4; c++) begin
            rem_ff[c]  <= rdata_ff[c*SUMW +: SUMW];
            quot_ff[c] <= '0;
         end
      end else if (div_go) begin
         div_ff  <= div_ff >> 1;
         step_ff <= step_ff - 1'b1;
         for (int c = 0; c < 4; c++) begin
            rem_ff[c]  <= rem_in[c];
            quot_ff[c] <= quot_in[c];
         end
         if (step_ff == 3'd0) begin
            opix_ff  <= {quot_in[3], quot_in[2], quot_in[1], quot_in[0]};
            olast_ff <= last_ff;
         end
      end
   end

endmodule

/* rtl/mosaic_block_average_core.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: pixel_in; tuser: cmd
// rsp       out        rsp_tvalid/rsp_tready  tdata: pixel_out; tlast: last
// csr       in         csr_we                 csr_index, csr_wdata
//
// A load is a read-modify-write in the execution unit, since the tile
// sum memory has one port with a registered read, and a read runs an
// 8-step divider for each channel, all sharing one divisor register.
// The 2-entry queue accepts requests while the execution unit is busy.
// Reset is synchronous; the tile sum memory is not cleared, since every
// tile is written by its first pixel before it is read back.
module mosaic_block_average_core
   import mba_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight,
   parameter int MAX_MOSAIC = DefMaxMosaic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_in
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pixel_out
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int MW    = $clog2(MAX_MOSAIC + 1);
   localparam int CNTW  = 2 * MW;
   localparam int DEPTH = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2);
   localparam int AW    = $clog2(DEPTH);

   logic [9:0] fw_ff, fh_ff, ms_ff;
   logic [XW-1:0] eff_w;
   logic [YW-1:0] eff_h;
   logic [MW-1:0] eff_m;
   logic restart;

   op_type           q_op;
   logic             q_valid, q_pop, q_first, q_last;
   logic [AW-1:0]    q_addr;
   logic [31:0]      q_pixel;
   logic [CNTW-1:0]  q_cnt;
   front_status_type status;

   assign restart = csr_we && ((csr_index == RegFrameWidth) ||
                               (csr_index == RegFrameHeight) ||
                               (csr_index == RegMosaicSize));

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= ResetFrameWidth;
         fh_ff <= ResetFrameHeight;
         ms_ff <= ResetMosaicSize;
      end else if (csr_we) begin
         case (csr_index)
            RegFrameWidth:  fw_ff <= csr_wdata;
            RegFrameHeight: fh_ff <= {1'b0, csr_wdata[8:0]};
            RegMosaicSize:  ms_ff <= {3'b0, csr_wdata[6:0]};
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_w = (int'(fw_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH)
            : (fw_ff == '0) ? XW'(1) : XW'(fw_ff);
      eff_h = (int'(fh_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT)
            : (fh_ff == '0) ? YW'(1) : YW'(fh_ff);
      eff_m = (int'(ms_ff) > MAX_MOSAIC) ? MW'(MAX_MOSAIC)
            : (int'(ms_ff) < 2) ? MW'(2) : MW'(ms_ff);
   end

   mba_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_MOSAIC(MAX_MOSAIC)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .w        (eff_w),
      .h        (eff_h),
      .m        (eff_m),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_cmd  (req_tuser),
      .req_pixel(req_tdata),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_op     (q_op),
      .q_addr   (q_addr),
      .q_first  (q_first),
      .q_pixel  (q_pixel),
      .q_cnt    (q_cnt),
      .q_last   (q_last),
      .status   (status)
   );

   mba_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_MOSAIC(MAX_MOSAIC)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_op     (q_op),
      .q_addr   (q_addr),
      .q_first  (q_first),
      .q_pixel  (q_pixel),
      .q_cnt    (q_cnt),
      .q_last   (q_last),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_pixel(rsp_tdata),
      .out_last (rsp_tlast)
   );

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      status.q_count != 2'd3)
      else $error("request queue overflow");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> !status.frame_ready)
      else $error("frame still complete after a register write");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("execution unit took an entry from an empty queue");

endmodule

/* bench/tb_mosaic_block_average_core.sv */
`timescale 1ns / 1ps

module tb_mosaic_block_average_core;
   import mba_pkg::*;

   localparam int TileDepth  = ((DefMaxWidth + 1) / 2) * ((DefMaxHeight + 1) / 2);
   localparam int DrainWait  = 40;
   localparam int StallLimit = 3000;
   localparam int LongHold   = 300;

   typedef struct {
      op_type      op;
      logic [31:0] pixel;
   } pixel_request_type;

   typedef struct {
      logic [31:0] pixel;
      logic        last;
   } tile_average_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [9:0]  csr_wdata;

   mosaic_block_average_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pixel_request_type pending_pixels[$];
   tile_average_type  avg_expected[$];
   int             error_count = 0;
   int             request_budget = 0;
   int             results_seen = 0;

   // Shadow registers and frame state of the mosaic predictor.
   logic [9:0]  width_reg;
   logic [8:0]  height_reg;
   logic [6:0]  mosaic_reg;
   int unsigned load_x, load_y, read_x, read_y;
   bit          frame_loaded;
   int unsigned tile_sum[4][TileDepth];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > DefMaxWidth) return DefMaxWidth;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > DefMaxHeight) return DefMaxHeight;
      return height_reg;
   endfunction

   function automatic int unsigned eff_mosaic();
      if (mosaic_reg < 2) return 2;
      if (mosaic_reg > DefMaxMosaic) return DefMaxMosaic;
      return mosaic_reg;
   endfunction

   function automatic int unsigned tile_of(int unsigned x, int unsigned y);
      int unsigned m;
      int unsigned idx;
      m = eff_mosaic();
      idx = (y / m) * ((eff_width() + m - 1) / m) + x / m;
      return (idx < TileDepth) ? idx : 0;
   endfunction

   function automatic void restart_frame();
      load_x = 0;
      load_y = 0;
      read_x = 0;
      read_y = 0;
      frame_loaded = 1'b0;
   endfunction

   // Applies one accepted request to the predictor and queues any tile average it yields.
   function automatic void predict_mosaic(pixel_request_type r);
      int unsigned w, h, m, idx, cw, ch, cnt, avg, x0, y0;
      logic [31:0] packed_avg;
      tile_average_type res;
      w = eff_width();
      h = eff_height();
      m = eff_mosaic();
      if (r.op == OP_LOAD) begin
         if (frame_loaded) return;
         idx = tile_of(load_x, load_y);
         for (int c = 0; c < 4; c++) begin
            if ((load_x % m == 0) && (load_y % m == 0))
               tile_sum[c][idx] = r.pixel[8*c +: 8];
            else
               tile_sum[c][idx] = (tile_sum[c][idx] + r.pixel[8*c +: 8]) & 24'hFFFFFF;
         end
         load_x++;
         if (load_x >= w) begin
            load_x = 0;
            load_y++;
            if (load_y >= h) begin
               load_y = 0;
               frame_loaded = 1'b1;
            end
         end
      end else begin
         if (!frame_loaded) return;
         idx = tile_of(read_x, read_y);
         x0 = (read_x / m) * m;
         y0 = (read_y / m) * m;
         cw = (w - x0 < m) ? w - x0 : m;
         ch = (h - y0 < m) ? h - y0 : m;
         cnt = cw * ch;
         for (int c = 0; c < 4; c++) begin
            avg = tile_sum[c][idx] / cnt;
            packed_avg[8*c +: 8] = (avg > 255) ? 8'hFF : avg[7:0];
         end
         res.pixel = packed_avg;
         res.last = (read_x + 1 >= w) && (read_y + 1 >= h);
         avg_expected.push_back(res);
         read_x++;
         if (read_x >= w) begin
            read_x = 0;
            read_y++;
            if (read_y >= h) begin
               read_y = 0;
               frame_loaded = 1'b0;
            end
         end
      end
   endfunction

   // Request driver.
   int send_gap;
   bit send_idling;
   always @(posedge clock) begin
      pixel_request_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         send_gap = 0;
         send_idling = 1'b1;
      end else begin
         if (req_tvalid && req_tready)
            predict_mosaic('{op: op_type'(req_tuser), pixel: req_tdata});
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               r = pending_pixels.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= r.pixel;
               req_tuser <= r.op;
               if ($urandom_range(63) == 0) send_idling = !send_idling;
               send_gap = send_idling ? $urandom_range(17) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stalls.
   int recv_gap;
   int hold_left;
   bit recv_idling;
   always @(posedge clock) begin
      tile_average_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
         hold_left = 0;
         recv_idling = 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (avg_expected.size() == 0) begin
               $error("unexpected result pixel_out=%h last=%b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               e = avg_expected.pop_front();
               if (rsp_tdata !== e.pixel) begin
                  $error("pixel_out expected %h actual %h", e.pixel, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last expected %b actual %b", e.last, rsp_tlast);
                  error_count++;
               end
            end
            if ($urandom_range(63) == 0) recv_idling = !recv_idling;
            recv_gap = recv_idling ? $urandom_range(17) : 0;
            // Every so often the receiver backs off long enough to fill the block.
            if (results_seen % 150 == 20) hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || avg_expected.size() != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [9:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         RegFrameWidth:  width_reg = value;
         RegFrameHeight: height_reg = value[8:0];
         RegMosaicSize:  mosaic_reg = value[6:0];
         default: ;
      endcase
      restart_frame();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(logic [9:0] w, logic [9:0] h, logic [9:0] m);
      wait_drained();
      write_reg(RegFrameWidth, w);
      write_reg(RegFrameHeight, h);
      write_reg(RegMosaicSize, m);
   endtask

   function automatic logic [31:0] draw_pixel();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Queues one frame of loads then reads, with ignored requests mixed in;
   // a cut frame stops part way and is abandoned by the next register write.
   task automatic queue_frame(bit cut);
      int total;
      int stop;
      op_type op;
      total = 2 * eff_width() * eff_height();
      stop = cut ? $urandom_range(total - 1, 1) : total;
      for (int k = 0; k < stop; k++) begin
         op = (k < total / 2) ? OP_LOAD : OP_READ;
         if ($urandom_range(19) == 0)
            pending_pixels.push_back('{op: (op == OP_LOAD) ? OP_READ : OP_LOAD,
                                       pixel: draw_pixel()});
         pending_pixels.push_back('{op: op, pixel: draw_pixel()});
         request_budget++;
      end
   endtask

   // Queues a whole frame of loads and only the first few reads of it.
   task automatic queue_partial(int reads);
      int loads;
      loads = eff_width() * eff_height();
      for (int k = 0; k < loads; k++)
         pending_pixels.push_back('{op: OP_LOAD, pixel: draw_pixel()});
      for (int k = 0; k < reads; k++)
         pending_pixels.push_back('{op: OP_READ, pixel: draw_pixel()});
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      width_reg = ResetFrameWidth;
      height_reg = ResetFrameHeight[8:0];
      mosaic_reg = ResetMosaicSize[6:0];
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero-sized registers clamp to a single pixel with a mosaic size of two.
      set_frame(10'd0, 10'd0, 10'd0);
      pending_pixels.push_back('{op: OP_READ, pixel: 32'h0});
      pending_pixels.push_back('{op: OP_LOAD, pixel: 32'hFFFF_FFFF});
      pending_pixels.push_back('{op: OP_LOAD, pixel: 32'h1234_5678});
      pending_pixels.push_back('{op: OP_READ, pixel: 32'h0});
      pending_pixels.push_back('{op: OP_READ, pixel: 32'h0});
      // Mosaic size of one behaves as two, with clipped edge tiles.
      set_frame(10'd3, 10'd3, 10'd1);
      for (int k = 0; k < 9; k++)
         pending_pixels.push_back('{op: OP_LOAD, pixel: (k % 2) ? 32'hFFFF_FFFF : 32'h0});
      for (int k = 0; k < 9; k++)
         pending_pixels.push_back('{op: OP_READ, pixel: 32'h0});

      // Widest and tallest frames, with oversized values that saturate.
      set_frame(10'd1023, 10'd1, 10'd127);
      queue_partial(40);
      set_frame(10'd1, 10'd511, 10'd64);
      queue_partial(4);

      request_budget = 0;
      while (request_budget < 300) begin
         case ($urandom_range(9))
            0: set_frame(10'($urandom_range(20)), 10'($urandom_range(12)),
                         10'($urandom_range(1)));
            1: set_frame(10'($urandom_range(20)), 10'($urandom_range(12)),
                         10'($urandom_range(127, 64)));
            default: set_frame(10'($urandom_range(16)), 10'($urandom_range(10)),
                               10'($urandom_range(9, 2)));
         endcase
         queue_frame($urandom_range(9) == 0);
         // Sometimes a second frame follows without reprogramming.
         if ($urandom_range(3) == 0) queue_frame(1'b0);
      end

      wait_drained();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/mba_pkg.sv
rtl/mba_walk.sv
rtl/mba_front.sv
rtl/mba_back.sv
rtl/mosaic_block_average_core.sv
bench/tb_mosaic_block_average_core.sv
